// ===== src/rtt_pkg.sv =====
// shared types and constants of the retransmission timer table
`timescale 1ns / 1ps

package rtt_pkg;

  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 20;
  localparam int TIMEOUT_W   = 20;
  localparam int RETRY_W     = 8;

  localparam int IN_TDATA_W  = 128;
  localparam int OUT_TDATA_W = 72;

  // bit positions inside the output tdata
  localparam int OUT_ACCEPTED_BIT = 0;
  localparam int OUT_KILL_BIT     = 65;

  // flag byte bits
  localparam int FLAG_FIN = 0;
  localparam int FLAG_SYN = 1;

  localparam logic [TIMEOUT_W-1:0] INITIAL_TIMEOUT_RST = 20'd1000;
  localparam logic [TIMEOUT_W-1:0] MAX_TIMEOUT_RST     = 20'd60000;
  localparam logic [RETRY_W-1:0]   MAX_RETRIES_RST     = 8'd8;
  localparam logic [RETRY_W-1:0]   FIN_MAX_RETRIES_RST = 8'd3;

  typedef enum logic [1:0] {
    ACT_ENQUEUE = 2'd0,
    ACT_ACK     = 2'd1,
    ACT_TICK    = 2'd2,
    ACT_FLUSH   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    KIND_ENQ_REPLY  = 2'd0,
    KIND_RETRANSMIT = 2'd1,
    KIND_RELEASE    = 2'd2,
    KIND_DONE       = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INITIAL_TIMEOUT = 2'd0,
    CFG_MAX_TIMEOUT     = 2'd1,
    CFG_MAX_RETRIES     = 2'd2,
    CFG_FIN_MAX_RETRIES = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [TIMEOUT_W-1:0] initial_timeout;
    logic [TIMEOUT_W-1:0] max_timeout;
    logic [RETRY_W-1:0]   max_retries;
    logic [RETRY_W-1:0]   fin_max_retries;
  } cfg_t;

  typedef struct packed {
    action_t     action;
    logic [31:0] seq;
    logic [7:0]  flags;
    logic [15:0] length;
    logic [7:0]  buffer;
    logic [31:0] ack;
    logic [31:0] now;
  } item_t;

  typedef struct packed {
    kind_t       kind;
    logic        accepted;
    logic [31:0] seq;
    logic [7:0]  flags;
    logic [15:0] length;
    logic [7:0]  buffer;
    logic        kill;
    logic        last;
  } result_t;

endpackage

// ===== src/tcp_retransmit_timer_table.sv =====
// top level of the tcp retransmission timer table
//
//   channel  dir  handshake         payload
//   s_*      in   s_tvalid/tready   tuser action, tdata segment, ack and time fields
//   m_*      out  m_tvalid/tready   tuser result kind, tlast last, tdata result fields
//   cfg_*    in   cfg_write         cfg_index register, cfg_data value
//
// one input item is in work at a time; s_tready is high only while idle
// enqueue: first-free search one slot per cycle, then a reply item, accepted set
//   for the first free slot and clear when the table is full
// ack, tick, flush: the slot ram's single read port walks one slot per cycle
//   while no emitted item waits on m_tready, then the done item follows
// reset clears the valid bits directly, so no clearing pass is needed
// a held output item never blocks the engine from loading the next once taken
`timescale 1ns / 1ps

module tcp_retransmit_timer_table import rtt_pkg::*; #(
  parameter int ENTRIES  = 16,
  parameter int TAG_BITS = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  // stream input
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // seq_number, seg_flags, seg_length, buffer_tag, ack_number, now_ms
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // action
  input  logic [1:0]             s_tuser,
  // stream output
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // accepted, out_seq, out_flags, out_length, out_buffer, kill, zero pad
  output logic [OUT_TDATA_W-1:0] m_tdata,
  // result_kind
  output logic [1:0]             m_tuser,
  output logic                   m_tlast,
  // configuration write port
  input  logic                   cfg_write,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t    cfg;
  item_t   in_item;
  result_t res;
  result_t out_q;
  logic    res_valid;
  logic    res_ready;

  rtt_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // unpack the input item, first field in the low bits
  always_comb begin
    in_item.action = action_t'(s_tuser);
    in_item.seq    = s_tdata[31:0];
    in_item.flags  = s_tdata[39:32];
    in_item.length = s_tdata[55:40];
    in_item.buffer = s_tdata[63:56];
    in_item.ack    = s_tdata[95:64];
    in_item.now    = s_tdata[127:96];
  end

  rtt_engine #(
    .ENTRIES  (ENTRIES),
    .TAG_BITS (TAG_BITS)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_item   (in_item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // output register: loads whenever empty or being drained
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_tdata = {6'd0, out_q.kill, out_q.buffer, out_q.length, out_q.flags,
                    out_q.seq, out_q.accepted};
  assign m_tuser = out_q.kind;
  assign m_tlast = out_q.last;

endmodule

// ===== src/rtt_ram.sv =====
// generic single-port-write ram with registered read
`timescale 1ns / 1ps

module rtt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/rtt_cfg_regs.sv =====
// configuration registers of the retransmission timer table
`timescale 1ns / 1ps

module rtt_cfg_regs import rtt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.initial_timeout <= INITIAL_TIMEOUT_RST;
      cfg.max_timeout     <= MAX_TIMEOUT_RST;
      cfg.max_retries     <= MAX_RETRIES_RST;
      cfg.fin_max_retries <= FIN_MAX_RETRIES_RST;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_INITIAL_TIMEOUT: cfg.initial_timeout <= cfg_data;
        CFG_MAX_TIMEOUT:     cfg.max_timeout     <= cfg_data;
        CFG_MAX_RETRIES:     cfg.max_retries     <= cfg_data[RETRY_W-1:0];
        CFG_FIN_MAX_RETRIES: cfg.fin_max_retries <= cfg_data[RETRY_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== src/rtt_engine.sv =====
// slot table: valid bits, slot ram and the enqueue / scan sequencer
`timescale 1ns / 1ps

module rtt_engine import rtt_pkg::*; #(
  parameter int ENTRIES  = 16,
  parameter int TAG_BITS = 8
) (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    in_valid,
  output logic    in_ready,
  input  item_t   in_item,
  output logic    res_valid,
  input  logic    res_ready,
  output result_t res
);

  localparam int IW = $clog2(ENTRIES);
  localparam int TW = (TAG_BITS < 8) ? TAG_BITS : 8;
  localparam logic [IW:0]   CNT_END  = (IW + 1)'(ENTRIES);
  localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

  typedef struct packed {
    logic [RETRY_W-1:0]   retries;
    logic [TIMEOUT_W-1:0] timeout;
    logic [31:0]          sent;
    logic [TW-1:0]        buffer;
    logic [15:0]          length;
    logic [7:0]           flags;
    logic [31:0]          seq;
  } slot_t;

  localparam int SW = $bits(slot_t);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ENQ,
    S_REPLY,
    S_SCAN,
    S_DONE
  } state_t;

  state_t             state;
  item_t              item;
  logic [IW:0]        cnt;
  logic               e_v;
  logic [IW-1:0]      e_idx;
  logic               kill_seen;
  logic               acc;
  logic [ENTRIES-1:0] valid;

  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  logic [SW-1:0] ram_wdata;
  logic          ram_re;
  logic [SW-1:0] ram_rdata;

  slot_t rd;
  slot_t wb;
  slot_t new_slot;

  logic                 issued_all;
  logic                 enq_free;
  logic                 e_live;
  logic                 has_buf;
  logic                 syn;
  logic                 fin;
  logic [31:0]          seg_end;
  logic [31:0]          ack_gap;
  logic [31:0]          elapsed;
  logic                 expired;
  logic                 fin_only;
  logic [RETRY_W-1:0]   budget;
  logic [TIMEOUT_W:0]   dbl;
  logic [TIMEOUT_W-1:0] new_timeout;
  logic                 e_emit;
  logic                 e_clear;
  logic                 e_wb;
  logic                 e_kill;
  result_t              e_res;
  logic                 advance;

  rtt_ram #(
    .WIDTH (SW),
    .DEPTH (ENTRIES)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (cnt[IW-1:0]),
    .rdata (ram_rdata)
  );

  assign rd         = slot_t'(ram_rdata);
  assign issued_all = (cnt == CNT_END);
  assign enq_free   = !valid[cnt[IW-1:0]];
  assign in_ready   = (state == S_IDLE);

  // slot evaluation on the registered read word of slot e_idx
  always_comb begin
    e_live      = e_v && valid[e_idx];
    has_buf     = (rd.length != 16'd0);
    syn         = rd.flags[FLAG_SYN];
    fin         = rd.flags[FLAG_FIN];
    seg_end     = rd.seq + {16'd0, rd.length} + {30'd0, syn & fin, syn ^ fin};
    ack_gap     = item.ack - seg_end;
    elapsed     = item.now - rd.sent;
    expired     = (elapsed >= {12'd0, rd.timeout});
    fin_only    = !has_buf && fin;
    budget      = fin_only ? cfg.fin_max_retries : cfg.max_retries;
    dbl         = {rd.timeout, 1'b0};
    new_timeout = (dbl > {1'b0, cfg.max_timeout}) ? cfg.max_timeout : dbl[TIMEOUT_W-1:0];

    e_emit  = 1'b0;
    e_clear = 1'b0;
    e_wb    = 1'b0;
    e_kill  = 1'b0;
    e_res   = '0;
    e_res.buffer = 8'(rd.buffer);

    if (e_live) begin
      case (item.action)
        ACT_ACK: begin
          if (!ack_gap[31]) begin
            e_clear    = 1'b1;
            e_emit     = has_buf;
            e_res.kind = KIND_RELEASE;
          end
        end
        ACT_TICK: begin
          if (expired) begin
            if (rd.retries >= budget) begin
              e_kill = 1'b1;
            end else begin
              e_emit       = 1'b1;
              e_wb         = 1'b1;
              e_res.kind   = KIND_RETRANSMIT;
              e_res.seq    = rd.seq;
              e_res.flags  = rd.flags;
              e_res.length = rd.length;
            end
          end
        end
        ACT_FLUSH: begin
          e_clear    = 1'b1;
          e_emit     = has_buf;
          e_res.kind = KIND_RELEASE;
        end
        default: ;
      endcase
    end

    if (!e_emit) begin
      e_res.buffer = 8'd0;
    end

    advance = !e_emit || res_ready;

    wb         = rd;
    wb.retries = rd.retries + 1'b1;
    wb.sent    = item.now;
    wb.timeout = new_timeout;

    new_slot.retries = '0;
    new_slot.timeout = cfg.initial_timeout;
    new_slot.sent    = item.now;
    new_slot.buffer  = item.buffer[TW-1:0];
    new_slot.length  = item.length;
    new_slot.flags   = item.flags;
    new_slot.seq     = item.seq;
  end

  // ram port control
  always_comb begin
    ram_re    = (state == S_SCAN) && advance && !issued_all;
    ram_we    = 1'b0;
    ram_waddr = e_idx;
    ram_wdata = wb;
    if (state == S_ENQ) begin
      ram_we    = enq_free;
      ram_waddr = cnt[IW-1:0];
      ram_wdata = new_slot;
    end else if (state == S_SCAN) begin
      ram_we = e_wb && advance;
    end
  end

  // result selection
  always_comb begin
    res       = '0;
    res_valid = 1'b0;
    unique case (state)
      S_REPLY: begin
        res_valid    = 1'b1;
        res.kind     = KIND_ENQ_REPLY;
        res.accepted = acc;
        res.last     = 1'b1;
      end
      S_SCAN: begin
        res_valid = e_emit;
        res       = e_res;
      end
      S_DONE: begin
        res_valid = 1'b1;
        res.kind  = KIND_DONE;
        res.kill  = kill_seen;
        res.last  = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      valid <= '0;
      e_v   <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            item      <= in_item;
            cnt       <= '0;
            e_v       <= 1'b0;
            kill_seen <= 1'b0;
            state     <= (in_item.action == ACT_ENQUEUE) ? S_ENQ : S_SCAN;
          end
        end
        S_ENQ: begin
          if (enq_free) begin
            valid[cnt[IW-1:0]] <= 1'b1;
            acc                <= 1'b1;
            state              <= S_REPLY;
          end else if (cnt[IW-1:0] == LAST_IDX) begin
            acc   <= 1'b0;
            state <= S_REPLY;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_REPLY: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        S_SCAN: begin
          if (advance) begin
            if (e_clear) begin
              valid[e_idx] <= 1'b0;
            end
            if (e_kill) begin
              kill_seen <= 1'b1;
            end
            if (!issued_all) begin
              e_v   <= 1'b1;
              e_idx <= cnt[IW-1:0];
              cnt   <= cnt + 1'b1;
            end else begin
              e_v <= 1'b0;
            end
          end
          if (issued_all && !e_v) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== src/rtt_checker.sv =====
// port-level checks of the retransmission timer table, bound to the top level
`timescale 1ns / 1ps

module rtt_checker import rtt_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tvalid,
  input logic                   s_tready,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata,
  input logic [1:0]             m_tuser,
  input logic                   m_tlast
);

  // one item in work at a time: input closes right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted while an item is still in work");

  // stalled output holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("output item changed while stalled");

  // only reply and done items close an input item
  a_last_kind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == (m_tuser == KIND_ENQ_REPLY || m_tuser == KIND_DONE)))
    else $error("last flag on wrong result kind");

  // kill appears only on a done item
  a_kill_done: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[OUT_KILL_BIT] |-> m_tuser == KIND_DONE)
    else $error("kill outside a done item");

  // accepted appears only on an enqueue reply
  a_acc_reply: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[OUT_ACCEPTED_BIT] |-> m_tuser == KIND_ENQ_REPLY)
    else $error("accepted outside an enqueue reply");

endmodule

bind tcp_retransmit_timer_table rtt_checker u_rtt_checker (.*);
